>>> rtl/binary_max_heap_queue_assert.svh
// Assertion macros shared by the checker.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BMHQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int KEY_W       = 32;
  localparam int COUNT_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int ENTRIES_DEF = 15;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_OVF,
    OP_UNF,
    OP_INS,
    OP_RM,
    OP_RD_PARENT,
    OP_MOVE_UP,
    OP_PLACE,
    OP_TAKE_LAST,
    OP_RD_LEFT,
    OP_CAP_LEFT,
    OP_PICK_RIGHT,
    OP_MOVE_DN,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic is_rm;
    logic full;
    logic empty;
    logic cnt_one;
    logic pos_root;
    logic has_left;
    logic has_right;
    logic parent_less;
    logic child_greater;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/bmhq_req_if.sv
`timescale 1ns / 1ps
interface bmhq_req_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  bmhq_pkg::key_t    key_in;

  modport source (output valid, output cmd, output key_in, input ready);
  modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

>>> rtl/bmhq_rsp_if.sv
`timescale 1ns / 1ps
interface bmhq_rsp_if;
  logic                          valid;
  logic                          ready;
  bmhq_pkg::key_t                removed_key;
  bmhq_pkg::key_t                top_key;
  logic [bmhq_pkg::COUNT_W-1:0]  entry_count;
  logic [bmhq_pkg::STATUS_W-1:0] status;

  modport source (output valid, output removed_key, output top_key,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input removed_key, input top_key,
                  input entry_count, input status, output ready);
endinterface

>>> rtl/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// Max-priority queue of signed 32-bit keys held as a one-based binary heap of
// up to ENTRIES keys in a single-port-write, registered-read memory. Each
// request inserts a key (cmd 0) or removes the largest key (cmd 1) and yields
// one response with the removed key, the new top key, the entry count and a
// status (ok, overflow on a full insert, underflow on an empty remove). One
// request is worked at a time by a sequencer that drives the datapath over
// the memory's one read port. An insert moves the new key up past each
// smaller parent; a remove moves the last key to the root and sinks it
// past each larger child, skipping the right-child read at a node that
// has no right child. A refused insert, a remove from an empty heap and a
// remove of the last key go straight to the result. A finished response
// waits in an output register while the next request is taken, and a
// second one holds the sequencer until that register is free. The memory
// needs no clearing after reset.
module binary_max_heap_queue #(
  parameter int ENTRIES = bmhq_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  bmhq_req_if.sink  req,
  bmhq_rsp_if.source rsp
);

  bmhq_pkg::op_t        op;
  bmhq_pkg::dp_status_t stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .op        (op)
  );

  bmhq_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .stat            (stat),
    .req_cmd         (req.cmd),
    .req_key         (req.key_in),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_removed_key (rsp.removed_key),
    .rsp_top_key     (rsp.top_key),
    .rsp_entry_count (rsp.entry_count),
    .rsp_status      (rsp.status)
  );

endmodule

>>> rtl/bmhq_ctrl.sv
`timescale 1ns / 1ps
module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  bmhq_pkg::dp_status_t stat,
  output bmhq_pkg::op_t        op
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHECK    = 10'b00_0000_0010,
    S_UP       = 10'b00_0000_0100,
    S_UP_CMP   = 10'b00_0000_1000,
    S_DN_LAST  = 10'b00_0001_0000,
    S_DN       = 10'b00_0010_0000,
    S_DN_LEFT  = 10'b00_0100_0000,
    S_DN_RIGHT = 10'b00_1000_0000,
    S_DN_CMP   = 10'b01_0000_0000,
    S_RESULT   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = bmhq_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         = bmhq_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_rm && stat.full) begin
          op         = bmhq_pkg::OP_OVF;
          state_next = S_RESULT;
        end else if (stat.is_rm && stat.empty) begin
          op         = bmhq_pkg::OP_UNF;
          state_next = S_RESULT;
        end else if (!stat.is_rm) begin
          op         = bmhq_pkg::OP_INS;
          state_next = S_UP;
        end else begin
          op         = bmhq_pkg::OP_RM;
          state_next = stat.cnt_one ? S_RESULT : S_DN_LAST;
        end
      end
      S_UP: begin
        if (stat.pos_root) begin
          op         = bmhq_pkg::OP_PLACE;
          state_next = S_RESULT;
        end else begin
          op         = bmhq_pkg::OP_RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_less) begin
          op         = bmhq_pkg::OP_MOVE_UP;
          state_next = S_UP;
        end else begin
          op         = bmhq_pkg::OP_PLACE;
          state_next = S_RESULT;
        end
      end
      S_DN_LAST: begin
        op         = bmhq_pkg::OP_TAKE_LAST;
        state_next = S_DN;
      end
      S_DN: begin
        if (stat.has_left) begin
          op         = bmhq_pkg::OP_RD_LEFT;
          state_next = S_DN_LEFT;
        end else begin
          op         = bmhq_pkg::OP_PLACE;
          state_next = S_RESULT;
        end
      end
      S_DN_LEFT: begin
        op         = bmhq_pkg::OP_CAP_LEFT;
        state_next = stat.has_right ? S_DN_RIGHT : S_DN_CMP;
      end
      S_DN_RIGHT: begin
        op         = bmhq_pkg::OP_PICK_RIGHT;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.child_greater) begin
          op         = bmhq_pkg::OP_MOVE_DN;
          state_next = S_DN;
        end else begin
          op         = bmhq_pkg::OP_PLACE;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          op         = bmhq_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bmhq_dpath.sv
`timescale 1ns / 1ps
module bmhq_dpath #(
  parameter int ENTRIES = bmhq_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmhq_pkg::op_t                 op,
  output bmhq_pkg::dp_status_t          stat,
  input  logic                          req_cmd,
  input  bmhq_pkg::key_t                req_key,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bmhq_pkg::key_t                rsp_removed_key,
  output bmhq_pkg::key_t                rsp_top_key,
  output logic [bmhq_pkg::COUNT_W-1:0]  rsp_entry_count,
  output logic [bmhq_pkg::STATUS_W-1:0] rsp_status
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  bmhq_pkg::key_t mem [ENTRIES];

  logic              is_rm;
  logic [PW-1:0]     cnt;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     cpos;
  bmhq_pkg::key_t    key;
  bmhq_pkg::key_t    cval;
  bmhq_pkg::key_t    top;
  bmhq_pkg::key_t    removed;
  bmhq_pkg::status_t res_status;
  bmhq_pkg::key_t    rdata;

  logic [PW:0]       lpos;
  logic [PW:0]       rpos;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              we;
  bmhq_pkg::key_t    wdata;

  assign lpos  = {pos, 1'b0};
  assign rpos  = {pos, 1'b1};
  assign waddr = AW'(pos - 1'b1);

  always_comb begin
    raddr = '0;
    case (op)
      bmhq_pkg::OP_RM:        raddr = AW'(cnt - 1'b1);
      bmhq_pkg::OP_RD_PARENT: raddr = AW'((pos >> 1) - 1'b1);
      bmhq_pkg::OP_RD_LEFT:   raddr = AW'(lpos - 1'b1);
      bmhq_pkg::OP_CAP_LEFT:  raddr = AW'(lpos);
      default:                raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = key;
    case (op)
      bmhq_pkg::OP_PLACE: begin
        we    = 1'b1;
        wdata = key;
      end
      bmhq_pkg::OP_MOVE_UP: begin
        we    = 1'b1;
        wdata = rdata;
      end
      bmhq_pkg::OP_MOVE_DN: begin
        we    = 1'b1;
        wdata = cval;
      end
      default: begin
        we    = 1'b0;
        wdata = key;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    stat.is_rm         = is_rm;
    stat.full          = (cnt == PW'(ENTRIES));
    stat.empty         = (cnt == '0);
    stat.cnt_one       = (cnt == PW'(1));
    stat.pos_root      = (pos == PW'(1));
    stat.has_left      = (lpos <= {1'b0, cnt});
    stat.has_right     = (rpos <= {1'b0, cnt});
    stat.parent_less   = (key > rdata);
    stat.child_greater = (cval > key);
    stat.out_free      = !rsp_valid || rsp_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (op)
        bmhq_pkg::OP_INS: cnt <= cnt + 1'b1;
        bmhq_pkg::OP_RM:  cnt <= cnt - 1'b1;
        default:          cnt <= cnt;
      endcase
      if (op == bmhq_pkg::OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      bmhq_pkg::OP_LOAD: begin
        is_rm <= (req_cmd == bmhq_pkg::CMD_REMOVE);
        key   <= req_key;
      end
      bmhq_pkg::OP_OVF: begin
        removed    <= '0;
        res_status <= bmhq_pkg::ST_OVERFLOW;
      end
      bmhq_pkg::OP_UNF: begin
        removed    <= '0;
        res_status <= bmhq_pkg::ST_UNDERFLOW;
      end
      bmhq_pkg::OP_INS: begin
        removed    <= '0;
        res_status <= bmhq_pkg::ST_OK;
        pos        <= cnt + 1'b1;
      end
      bmhq_pkg::OP_RM: begin
        removed    <= top;
        res_status <= bmhq_pkg::ST_OK;
        pos        <= PW'(1);
      end
      bmhq_pkg::OP_MOVE_UP: begin
        if (pos == PW'(1)) begin
          top <= rdata;
        end
        pos <= pos >> 1;
      end
      bmhq_pkg::OP_PLACE: begin
        if (pos == PW'(1)) begin
          top <= key;
        end
      end
      bmhq_pkg::OP_TAKE_LAST: begin
        key <= rdata;
      end
      bmhq_pkg::OP_CAP_LEFT: begin
        cval <= rdata;
        cpos <= PW'(lpos);
      end
      bmhq_pkg::OP_PICK_RIGHT: begin
        // left wins a tie
        if (rdata > cval) begin
          cval <= rdata;
          cpos <= PW'(rpos);
        end
      end
      bmhq_pkg::OP_MOVE_DN: begin
        if (pos == PW'(1)) begin
          top <= cval;
        end
        pos <= cpos;
      end
      bmhq_pkg::OP_EMIT: begin
        rsp_removed_key <= removed;
        rsp_top_key     <= (cnt != '0) ? top : '0;
        rsp_entry_count <= bmhq_pkg::COUNT_W'(cnt);
        rsp_status      <= res_status;
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

>>> rtl/bmhq_checker.sv
`timescale 1ns / 1ps
`include "binary_max_heap_queue_assert.svh"
module bmhq_checker #(
  parameter int ENTRIES = bmhq_pkg::ENTRIES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input bmhq_pkg::key_t                rsp_removed_key,
  input bmhq_pkg::key_t                rsp_top_key,
  input logic [bmhq_pkg::COUNT_W-1:0]  rsp_entry_count,
  input logic [bmhq_pkg::STATUS_W-1:0] rsp_status
);

  `BMHQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_removed_key) && $stable(rsp_top_key) && $stable(rsp_entry_count) && $stable(rsp_status), "response changed while stalled")
  `BMHQ_ASSERT_NOW(a_underflow_zero, clk, rst, rsp_valid && rsp_status == bmhq_pkg::ST_UNDERFLOW, rsp_removed_key == '0 && rsp_top_key == '0 && rsp_entry_count == '0, "underflow response not cleared")
  `BMHQ_ASSERT_NOW(a_overflow_full, clk, rst, rsp_valid && rsp_status == bmhq_pkg::ST_OVERFLOW, rsp_removed_key == '0 && rsp_entry_count == bmhq_pkg::COUNT_W'(ENTRIES), "overflow reported on a heap that is not full")
  `BMHQ_ASSERT_NOW(a_empty_top, clk, rst, rsp_valid && rsp_entry_count == '0 && ENTRIES < 16, rsp_top_key == '0, "empty heap reports a top key")

endmodule

bind binary_max_heap_queue bmhq_checker #(
  .ENTRIES (ENTRIES)
) u_bmhq_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_removed_key (rsp.removed_key),
  .rsp_top_key     (rsp.top_key),
  .rsp_entry_count (rsp.entry_count),
  .rsp_status      (rsp.status)
);
